// ===== src/float_delta_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the delta encoder checks.
// ----------------------------------------------------------------------------
`ifndef FLOAT_DELTA_ENCODER_ASSERT_SVH
`define FLOAT_DELTA_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FDE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("delta encoder check failed");

// next-cycle implication, disabled during reset
`define FDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("delta encoder check failed");

`endif

// ===== src/fde_pkg.sv =====
// ----------------------------------------------------------------------------
// fde_pkg
// Codes and constants of the float delta encoder.
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam int CFG_IDX_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE    = 8'd0,
        CFG_FILTER_THRESHOLD = 8'd1,
        CFG_GROUP_NORM_EN    = 8'd2,
        CFG_GROUP_NORM_EXP   = 8'd3
    } t_cfg_idx;

    // result case codes
    typedef enum logic [1:0] {
        CASE_EQUAL    = 2'd0,
        CASE_MZERO    = 2'd1,
        CASE_FILTERED = 2'd2,
        CASE_ENCODED  = 2'd3
    } t_case;

    localparam logic [10:0] EXP_MAX   = 11'h7FF;
    localparam logic [12:0] EXP_BIAS  = 13'd1023;
    localparam logic [63:0] SIGN_WORD = 64'h8000_0000_0000_0000;

endpackage

// ===== src/float_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// float_delta_encoder
// Double-precision minuend minus subtrahend, packed into a delta word.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; the seven-register pipeline (input, unpack,
// align and add, leading-zero count, normalize and round, filter, pack and
// output) takes a new pair every cycle and holds all stages while the output stalls.
// Reset: synchronous active-low; clears valid bits and configuration.
module float_delta_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [63:0]                   i_subtrahend_bits,
    input  logic [63:0]                   i_minuend_bits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [63:0]                   o_delta_bits,
    output logic [1:0]                    o_case_code,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fde_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);
    import fde_pkg::*;

`include "float_delta_encoder_assert.svh"

    // configuration
    logic        r_filter_en;
    logic [63:0] r_threshold;
    logic        r_group_en;
    logic [11:0] r_group_exp;

    logic en;

    // stage 0: input registers
    logic        r0_v;
    logic [63:0] r0_s, r0_m;

    // stage 1: unpack and swap
    logic        r1_v, r1_spec, r1_sign, r1_sub;
    t_case       r1_code;
    logic [63:0] r1_spec_bits;
    logic [10:0] r1_ex, r1_diff, r1_mexp;
    logic [52:0] r1_mx, r1_my;

    // stage 2: aligned sum
    logic        r2_v, r2_spec, r2_sign;
    t_case       r2_code;
    logic [63:0] r2_spec_bits;
    logic [10:0] r2_ex, r2_mexp;
    logic [56:0] r2_sum;

    // stage 3: normalize amount
    logic        r3_v, r3_spec, r3_sign, r3_zero;
    t_case       r3_code;
    logic [63:0] r3_spec_bits;
    logic [10:0] r3_ex, r3_mexp;
    logic [56:0] r3_sum;
    logic [5:0]  r3_sh;

    // stage 4: rounded difference
    logic        r4_v;
    t_case       r4_code;
    logic [63:0] r4_d;
    logic [10:0] r4_mexp;

    // stage 5: filter and gap
    logic        r5_v, r5_wider;
    t_case       r5_code;
    logic [63:0] r5_d;
    logic [12:0] r5_k;
    logic [10:0] r5_exf;

    // output
    logic        r_out_v;
    t_case       r_out_code;
    logic [63:0] r_out_delta;

    // advance the whole pipeline unless the output beat is held
    assign en          = !r_out_v || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b0;
            r_threshold <= '0;
            r_group_en  <= 1'b0;
            r_group_exp <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FILTER_ENABLE:    r_filter_en <= i_cfg_data[0];
                CFG_FILTER_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_GROUP_NORM_EN:    r_group_en  <= i_cfg_data[0];
                CFG_GROUP_NORM_EXP:   r_group_exp <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // stage 1 logic: classify, pick larger magnitude, exponent gap
    logic [10:0] s_exp, m_exp, x_exp, y_exp, x_eff, y_eff;
    logic [51:0] s_frac, m_frac, x_frac, y_frac;
    logic        s_nan, m_nan, s_inf, m_inf, s_zero, m_zero, eq, swap;
    t_case       n1_code;
    logic [63:0] n1_spec_bits;

    always_comb begin
        s_exp  = r0_s[62:52];
        m_exp  = r0_m[62:52];
        s_frac = r0_s[51:0];
        m_frac = r0_m[51:0];
        s_nan  = (s_exp == EXP_MAX) && (s_frac != '0);
        m_nan  = (m_exp == EXP_MAX) && (m_frac != '0);
        s_inf  = (s_exp == EXP_MAX) && (s_frac == '0);
        m_inf  = (m_exp == EXP_MAX) && (m_frac == '0);
        s_zero = (r0_s[62:0] == '0);
        m_zero = (r0_m[62:0] == '0);
        eq     = !s_nan && !m_nan && ((r0_s == r0_m) || (s_zero && m_zero));
        if (eq) begin
            n1_code = CASE_EQUAL;
        end else if (m_zero) begin
            n1_code = CASE_MZERO;
        end else begin
            n1_code = CASE_ENCODED;
        end
        // special difference: quieted NaN operand or the infinite operand
        if (m_nan) begin
            n1_spec_bits = r0_m | 64'h0008_0000_0000_0000;
        end else if (s_nan) begin
            n1_spec_bits = r0_s | 64'h0008_0000_0000_0000;
        end else if (m_inf) begin
            n1_spec_bits = r0_m;
        end else begin
            n1_spec_bits = {~r0_s[63], r0_s[62:0]};
        end
        swap   = r0_s[62:0] > r0_m[62:0];
        x_exp  = swap ? s_exp : m_exp;
        y_exp  = swap ? m_exp : s_exp;
        x_frac = swap ? s_frac : m_frac;
        y_frac = swap ? m_frac : s_frac;
        x_eff  = (x_exp == '0) ? 11'd1 : x_exp;
        y_eff  = (y_exp == '0) ? 11'd1 : y_exp;
    end

    // stage 2 logic: align smaller operand with sticky, add or subtract
    logic [111:0] wide;
    logic [55:0]  y_al;
    logic         sticky;

    always_comb begin
        wide = {r1_my, 3'b000, 56'd0} >> r1_diff;
        if (r1_diff >= 11'd56) begin
            y_al = {55'd0, |r1_my};
        end else begin
            sticky = |wide[55:0];
            y_al   = {wide[111:57], wide[56] | sticky};
        end
        sticky = |wide[55:0];
    end

    // stage 3 logic: leading-zero count, clamped for subnormal results
    logic [5:0]  lz;
    logic [10:0] ex_m1;
    logic [5:0]  n3_sh;

    always_comb begin
        lz = 6'd56;
        for (int i = 0; i < 56; i++) begin
            if (r2_sum[i]) begin
                lz = 6'(55 - i);
            end
        end
        ex_m1 = r2_ex - 11'd1;
        if ({5'd0, lz} > ex_m1) begin
            n3_sh = ex_m1[5:0];
        end else begin
            n3_sh = lz;
        end
    end

    // stage 4 logic: normalize and round to nearest even
    logic [55:0] nrm;
    logic [11:0] e_res;
    logic        inc;
    logic [62:0] mag;
    logic [63:0] n4_d;

    always_comb begin
        if (r3_sum[56]) begin
            nrm   = {r3_sum[56:2], r3_sum[1] | r3_sum[0]};
            e_res = {1'b0, r3_ex} + 12'd1;
        end else begin
            nrm   = r3_sum[55:0] << r3_sh;
            e_res = nrm[55] ? ({1'b0, r3_ex} - {6'd0, r3_sh}) : 12'd0;
        end
        inc = nrm[2] && (nrm[1] || nrm[0] || nrm[3]);
        mag = {e_res[10:0], nrm[54:3]} + {62'd0, inc};
        if (r3_spec) begin
            n4_d = r3_spec_bits;
        end else if (r3_zero) begin
            n4_d = '0;
        end else if (e_res >= {1'b0, EXP_MAX}) begin
            n4_d = {r3_sign, EXP_MAX, 52'd0};
        end else begin
            n4_d = {r3_sign, mag};
        end
    end

    // stage 5 logic: threshold filter, exponent gap and shift count
    logic        d_nan, t_nan, filt;
    logic [12:0] em, em_b;
    logic [13:0] gap, gap_abs;
    t_case       n5_code;

    always_comb begin
        d_nan = (r4_d[62:52] == EXP_MAX) && (r4_d[51:0] != '0);
        t_nan = (r_threshold[62:52] == EXP_MAX) && (r_threshold[51:0] != '0);
        filt  = r_filter_en && !d_nan && !t_nan && !r_threshold[63]
                && (r4_d[62:0] < r_threshold[62:0]);
        n5_code = (r4_code == CASE_ENCODED && filt) ? CASE_FILTERED : r4_code;
        if (r_group_en) begin
            em = {r_group_exp[11], r_group_exp};
        end else begin
            em = {2'b00, r4_mexp} - EXP_BIAS;
        end
        em_b    = em + EXP_BIAS;
        gap     = {3'b000, r4_d[62:52]} - {1'b0, EXP_BIAS} - {em[12], em};
        gap_abs = gap[13] ? (14'd0 - gap) : gap;
    end

    // output logic: shifted fraction with marker and sign-of-gap bits
    logic [51:0] frac;
    logic [63:0] word;
    logic [63:0] n_delta;

    always_comb begin
        frac = (r5_k >= 13'd64) ? 52'd0 : (r5_d[51:0] >> r5_k[5:0]);
        if (r5_k <= 13'd53) begin
            frac = frac | (52'd1 << (6'd53 - r5_k[5:0]));
        end
        if (r5_wider && r5_k <= 13'd52) begin
            frac = frac | (52'd1 << (6'd52 - r5_k[5:0]));
        end
        word = {r5_d[63], r5_exf, frac};
        case (r5_code)
            CASE_EQUAL:    n_delta = '0;
            CASE_MZERO:    n_delta = SIGN_WORD;
            CASE_FILTERED: n_delta = '0;
            default:       n_delta = word;
        endcase
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r0_v    <= i_in_valid;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r_out_v <= r5_v;
        end
    end

    // payload registers, held while the output stalls
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_s <= i_subtrahend_bits;
            r0_m <= i_minuend_bits;

            r1_code      <= n1_code;
            r1_spec      <= s_nan || m_nan || s_inf || m_inf;
            r1_spec_bits <= n1_spec_bits;
            r1_sign      <= swap ? ~r0_s[63] : r0_m[63];
            r1_sub       <= (r0_m[63] == r0_s[63]);
            r1_ex        <= x_eff;
            r1_diff      <= x_eff - y_eff;
            r1_mx        <= {x_exp != '0, x_frac};
            r1_my        <= {y_exp != '0, y_frac};
            r1_mexp      <= m_exp;

            r2_code      <= r1_code;
            r2_spec      <= r1_spec;
            r2_spec_bits <= r1_spec_bits;
            r2_sign      <= r1_sign;
            r2_ex        <= r1_ex;
            r2_mexp      <= r1_mexp;
            r2_sum       <= r1_sub ? ({1'b0, r1_mx, 3'b000} - {1'b0, y_al})
                                   : ({1'b0, r1_mx, 3'b000} + {1'b0, y_al});

            r3_code      <= r2_code;
            r3_spec      <= r2_spec;
            r3_spec_bits <= r2_spec_bits;
            r3_sign      <= r2_sign;
            r3_zero      <= (r2_sum == '0);
            r3_ex        <= r2_ex;
            r3_mexp      <= r2_mexp;
            r3_sum       <= r2_sum;
            r3_sh        <= n3_sh;

            r4_code <= r3_code;
            r4_d    <= n4_d;
            r4_mexp <= r3_mexp;

            r5_code  <= n5_code;
            r5_d     <= r4_d;
            r5_wider <= !gap[13] && (gap != '0);
            r5_k     <= gap_abs[12:0] + 13'd2;
            r5_exf   <= em_b[10:0];

            r_out_code  <= r5_code;
            r_out_delta <= n_delta;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_delta_bits = r_out_delta;
    assign o_case_code  = r_out_code;

    // checks
    `FDE_ASSERT_NOW(a_stall_only_when_held, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall)
    `FDE_ASSERT_NEXT(a_freeze_holds_pipe, i_clk, i_rst_n, !en,
        $stable(r5_v) && $stable(r4_v) && $stable(r0_v))
    `FDE_ASSERT_NOW(a_zero_codes, i_clk, i_rst_n,
        o_out_valid && (o_case_code == CASE_EQUAL || o_case_code == CASE_FILTERED),
        o_delta_bits == '0)

endmodule

// ===== dv/tb_float_delta_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_float_delta_encoder
// Self-checking bench for the float delta encoder. Pairs of doubles go in
// under random gaps and output stalls. A scoreboard predicts each delta word
// and case code with native double arithmetic. It then compares them in
// order with the result beats, across several register settings.
// ----------------------------------------------------------------------------
module tb_float_delta_encoder;
    import fde_pkg::*;

    localparam int                  HALF_PERIOD    = 6;
    localparam int                  DRAIN_CYCLES   = 12;
    localparam int                  CYCLE_LIMIT    = 400000;
    localparam int                  HOLD_CYCLES    = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 8'd9;

    // double constants used by the directed part
    localparam logic [63:0] D_POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] D_NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [63:0] D_ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] D_TWO      = 64'h4000_0000_0000_0000;
    localparam logic [63:0] D_POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] D_NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] D_QNAN     = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] D_MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] D_MAX_NORM = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] D_MILLI    = 64'h3F50_624D_D2F1_A9FC;

    // ------------------------------------------------------------------------
    // Scoreboard: register copy, expected delta words, mismatch count
    // ------------------------------------------------------------------------
    class delta_scoreboard;
        bit          filt_en;
        bit   [63:0] thresh;
        bit          gn_en;
        bit   [11:0] gn_exp;
        bit   [63:0] exp_delta[$];
        t_case       exp_case[$];
        int          errors;
        int          n_in;
        int          n_out;
        int          case_seen[4];

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
            case (idx)
                CFG_FILTER_ENABLE:    filt_en = v[0];
                CFG_FILTER_THRESHOLD: thresh  = v;
                CFG_GROUP_NORM_EN:    gn_en   = v[0];
                CFG_GROUP_NORM_EXP:   gn_exp  = v[11:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return exp_delta.size();
        endfunction

        // predict the delta word for one accepted pair
        function void note_input(logic [63:0] sb, logic [63:0] mb);
            real         s;
            real         m;
            real         d;
            real         t;
            logic [63:0] db;
            logic [63:0] frac;
            logic [63:0] word;
            int          em;
            int          gap;
            int          k;
            int          ef;
            s = $bitstoreal(sb);
            m = $bitstoreal(mb);
            t = $bitstoreal(thresh);
            n_in++;
            if (s == m) begin
                exp_delta.push_back(64'd0);
                exp_case.push_back(CASE_EQUAL);
            end else if (m == 0.0) begin
                exp_delta.push_back(SIGN_WORD);
                exp_case.push_back(CASE_MZERO);
            end else begin
                d = m - s;
                if (filt_en && ((d < t && d >= 0.0) || (d > -t && d < 0.0))) begin
                    exp_delta.push_back(64'd0);
                    exp_case.push_back(CASE_FILTERED);
                end else begin
                    db = $realtobits(d);
                    if (gn_en)
                        em = int'($signed(gn_exp));
                    else
                        em = int'(mb[62:52]) - 1023;
                    gap  = int'(db[62:52]) - 1023 - em;
                    k    = (gap > 0 ? gap : -gap) + 2;
                    frac = (k >= 64) ? 64'd0 : ({12'd0, db[51:0]} >> k);
                    // add marker and sign-of-gap bits, drop those below bit 0
                    if (k <= 53)
                        frac[53-k] = 1'b1;
                    if (gap > 0 && k <= 52)
                        frac[52-k] = 1'b1;
                    ef   = em + 1023;
                    word = {db[63], ef[10:0], frac[51:0]};
                    exp_delta.push_back(word);
                    exp_case.push_back(CASE_ENCODED);
                end
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH beat %0d: %s", n_out, msg);
            errors++;
        endtask

        // compare one result beat with the oldest expectation
        task check_result(logic [63:0] d, logic [1:0] c);
            logic [63:0] ed;
            t_case       ec;
            if (exp_delta.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %h case %0d", d, c));
            end else begin
                ed = exp_delta.pop_front();
                ec = exp_case.pop_front();
                if (d !== ed)
                    report_mismatch($sformatf("delta %h, want %h", d, ed));
                if (c !== ec)
                    report_mismatch($sformatf("case %0d, want %0d", c, ec));
                case_seen[ec]++;
            end
            n_out++;
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [63:0]          i_subtrahend_bits;
    logic [63:0]          i_minuend_bits;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [63:0]          o_delta_bits;
    logic [1:0]           o_case_code;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [63:0]          i_cfg_data;

    delta_scoreboard sb = new();
    int              cycles;
    bit              hold_req;
    bit              no_gaps;
    int              hold_left;
    int              stall_left;
    int              free_left;

    float_delta_encoder dut (.*);

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending());
            $display("float_delta_encoder regression: fail");
            $finish;
        end
    end

    // check result beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_delta_bits, o_case_code);
    end

    // output stall: long hold on request, else random short/long stalls
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left--;
            i_out_stall <= 1'b0;
        end else begin
            free_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(0, 4);
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 3);
            i_out_stall <= 1'b0;
        end
    end

    // send one pair after a random gap; hold until accepted
    task send_pair(logic [63:0] s, logic [63:0] m);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 9) < 3)
            gap = ($urandom_range(0, 31) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 3);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_subtrahend_bits <= s;
        i_minuend_bits    <= m;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(s, m);
    endtask

    task drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for every expected beat, then let the pipeline drain
    task wait_idle();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task set_regs(bit fe, logic [63:0] th, bit ge, logic [11:0] gx);
        write_reg(CFG_FILTER_ENABLE, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FFFE | fe);
        write_reg(CFG_FILTER_THRESHOLD, th);
        write_reg(CFG_GROUP_NORM_EN, {63'd0, ge});
        write_reg(CFG_GROUP_NORM_EXP, {$urandom, 20'($urandom), gx});
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function logic [63:0] special_val();
        case ($urandom_range(0, 9))
            0: return D_POS_ZERO;
            1: return D_NEG_ZERO;
            2: return D_POS_INF;
            3: return D_NEG_INF;
            4: return D_QNAN | {1'b0, 11'd0, 1'b0, $urandom, 19'd0};
            5: return D_MIN_SUB;
            6: return D_MAX_NORM;
            7: return {1'($urandom_range(0, 1)), 11'd0, $urandom, 20'd0};
            8: return D_ONE;
            default: return rand64();
        endcase
    endfunction

    // mostly neighboring values, as a delta stream carries, plus noise
    task send_random();
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] flip;
        int          sel;
        int          ex;
        sel = $urandom_range(0, 99);
        m   = rand64();
        if (sel < 45) begin
            flip = rand64() >> $urandom_range(0, 63);
            s    = m ^ flip;
        end else if (sel < 65) begin
            ex = int'(m[62:52]) + $urandom_range(0, 120) - 60;
            if (ex < 1)    ex = 1;
            if (ex > 2046) ex = 2046;
            s = {1'($urandom_range(0, 1)), 11'(ex), 52'(rand64() >> 12)};
        end else if (sel < 72) begin
            s = m;
        end else if (sel < 78) begin
            s = rand64();
            m = $urandom_range(0, 1) ? D_NEG_ZERO : D_POS_ZERO;
        end else if (sel < 90) begin
            s = special_val();
            m = ($urandom_range(0, 1)) ? special_val() : m;
        end else begin
            s = rand64();
        end
        if ($urandom_range(0, 1))
            send_pair(m, s);
        else
            send_pair(s, m);
    endtask

    task send_burst(int n);
        repeat (n) send_random();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_out_stall       = 1'b0;
        i_subtrahend_bits = '0;
        i_minuend_bits    = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = '0;
        i_cfg_data        = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: equality, zero minuend, specials, gap extremes
        send_pair(D_ONE, D_ONE);
        send_pair(D_POS_ZERO, D_NEG_ZERO);
        send_pair(D_QNAN, D_QNAN);
        send_pair(D_ONE, D_POS_ZERO);
        send_pair(D_ONE, D_NEG_ZERO);
        send_pair(D_QNAN, D_POS_ZERO);
        send_pair(D_ONE, D_TWO);
        send_pair(D_TWO, D_ONE);
        send_pair(D_POS_INF, D_ONE);
        send_pair(D_ONE, D_POS_INF);
        send_pair(D_POS_INF, D_POS_INF);
        send_pair(D_NEG_INF, D_POS_INF);
        send_pair(D_POS_INF, D_NEG_INF);
        send_pair(D_ONE, D_ONE + 64'd1);
        send_pair(D_MIN_SUB, D_MAX_NORM);
        send_pair(D_MAX_NORM, D_MIN_SUB);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, D_ONE);
        send_pair(D_POS_ZERO, D_MIN_SUB);
        send_pair(D_ONE, 64'hFFEF_FFFF_FFFF_FFFF);
        drop_valid();
        wait_idle();

        // directed filter checks, then group exponent extremes
        set_regs(1'b1, D_ONE, 1'b0, 12'd0);
        send_pair(D_ONE, D_ONE + 64'd5);
        send_pair(D_ONE + 64'd5, D_ONE);
        send_pair(D_POS_ZERO, D_ONE);
        send_pair(D_TWO, D_ONE);
        send_pair(D_POS_ZERO, D_QNAN);
        send_burst(150);
        drop_valid();
        wait_idle();
        write_reg(CFG_IDX_UNUSED, rand64());

        set_regs(1'b0, D_MILLI, 1'b1, 12'hC01);
        send_burst(150);
        // long output hold while the sender keeps pushing
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        send_burst(80);
        no_gaps = 1'b0;
        drop_valid();
        wait_idle();

        set_regs(1'b1, D_MILLI, 1'b1, 12'h400);
        send_burst(150);
        drop_valid();
        wait_idle();
        send_burst(100);
        drop_valid();
        wait_idle();

        set_regs(1'b1, D_POS_INF, 1'b0, 12'h7FF);
        send_burst(150);
        drop_valid();
        wait_idle();

        set_regs(1'b1, D_QNAN, 1'b1, 12'h000);
        send_burst(120);
        drop_valid();
        wait_idle();

        set_regs(1'b1, D_NEG_INF, 1'b1, 12'hFFF);
        send_burst(120);
        drop_valid();
        wait_idle();

        // random register settings
        repeat (5) begin
            set_regs(1'($urandom_range(0, 1)),
                     {1'($urandom_range(0, 1)), 11'($urandom_range(900, 1100)),
                      52'(rand64() >> 12)},
                     1'($urandom_range(0, 1)), 12'($urandom));
            send_burst(120);
            drop_valid();
            wait_idle();
        end
        set_regs(1'b1, rand64(), 1'b1, 12'($urandom));
        send_burst(60);
        drop_valid();
        wait_idle();

        $display("covered %0d pairs: %0d equal, %0d zero minuend, %0d filtered, %0d encoded",
                 sb.n_in, sb.case_seen[CASE_EQUAL], sb.case_seen[CASE_MZERO],
                 sb.case_seen[CASE_FILTERED], sb.case_seen[CASE_ENCODED]);
        $display("register settings swept filter and group exponent extremes, %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("float_delta_encoder regression: pass");
        else
            $display("float_delta_encoder regression: fail");
        $finish;
    end

endmodule
